// File: sv/i2cms_pkg.sv
`default_nettype none
package i2cms_pkg;

  // Largest number of data bytes moved by one transfer
  localparam logic [7:0] MAX_TRANSFER = 8'd255;

  // Input actions
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  // Operation status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Acknowledge control
  localparam logic [1:0] ACK_KEEP  = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  // Controller status codes
  localparam logic [7:0] SC_START       = 8'h08;
  localparam logic [7:0] SC_RSTART      = 8'h10;
  localparam logic [7:0] SC_SLAW_ACK    = 8'h18;
  localparam logic [7:0] SC_SLAW_NACK   = 8'h20;
  localparam logic [7:0] SC_TXDATA_ACK  = 8'h28;
  localparam logic [7:0] SC_ARB_LOST    = 8'h38;
  localparam logic [7:0] SC_SLAR_ACK    = 8'h40;
  localparam logic [7:0] SC_RXDATA_ACK  = 8'h50;
  localparam logic [7:0] SC_RXDATA_NACK = 8'h58;

  localparam logic [7:0] DEV_WRITE_MASK = 8'hFE;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [9:0]  RETRY_RESET   = 10'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_LOWER,
    PH_DATA,
    PH_RDADDR
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  slave_address;
    logic [15:0] mem_address;
    logic        wide_address;
    logic [7:0]  byte_count;
    logic [7:0]  status_code;
    logic [7:0]  rx_data;
    logic [7:0]  tx_data;
  } item_t;

  typedef struct packed {
    logic       send_start;
    logic       send_stop;
    logic [1:0] ack_control;
    logic       clear_interrupt;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] byte_index;
    logic [1:0] op_status;
    logic       done_res;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [9:0]  retry_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        is_read;
    logic [1:0]  status;
    logic [7:0]  remaining;
    logic [7:0]  index;
    logic [7:0]  device;
    logic [15:0] address;
    logic        wide;
    logic [15:0] timeout_count;
    logic [9:0]  retry_count;
    logic        retry_running;
  } state_t;

endpackage
`default_nettype wire

// File: sv/i2cms_if.sv
`default_nettype none
interface i2cms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  slave_address;
  logic [15:0] mem_address;
  logic        wide_address;
  logic [7:0]  byte_count;
  logic [7:0]  status_code;
  logic [7:0]  rx_data;
  logic [7:0]  tx_data;

  modport source (
    output valid, action, slave_address, mem_address, wide_address, byte_count,
           status_code, rx_data, tx_data,
    input  ready
  );
  modport sink (
    input  valid, action, slave_address, mem_address, wide_address, byte_count,
           status_code, rx_data, tx_data,
    output ready
  );
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       send_start;
  logic       send_stop;
  logic [1:0] ack_control;
  logic       clear_interrupt;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic [7:0] byte_index;
  logic [1:0] op_status;
  logic       done_res;

  modport source (
    output valid, send_start, send_stop, ack_control, clear_interrupt, tx_valid,
           tx_byte, rx_valid, rx_byte, byte_index, op_status, done_res,
    input  ready
  );
  modport sink (
    input  valid, send_start, send_stop, ack_control, clear_interrupt, tx_valid,
           tx_byte, rx_valid, rx_byte, byte_index, op_status, done_res,
    output ready
  );
endinterface
`default_nettype wire

// File: sv/i2cms_step.sv
`default_nettype none
// Next state and actions for one item, purely combinational.
module i2cms_step #(
  parameter logic [7:0] MAX_TRANSFER = i2cms_pkg::MAX_TRANSFER
) (
  input  var i2cms_pkg::state_t  st,
  input  var i2cms_pkg::item_t   item,
  input  var i2cms_pkg::cfg_t    cfg,
  output i2cms_pkg::state_t      st_nxt,
  output i2cms_pkg::result_t     res
);

  logic        busy;
  logic        reject;
  logic [7:0]  cnt;
  logic [7:0]  rem_dec;
  logic [7:0]  idx_inc;
  logic [15:0] tmo_inc;
  logic        end_req;
  logic [1:0]  end_status;

  assign busy    = (st.status == i2cms_pkg::ST_BUSY);
  assign rem_dec = st.remaining - 8'd1;
  assign idx_inc = st.index + 8'd1;
  assign tmo_inc = (st.timeout_count != 16'hFFFF) ? st.timeout_count + 16'd1
                                                   : st.timeout_count;
  assign cnt = (item.byte_count > MAX_TRANSFER) ? MAX_TRANSFER : item.byte_count;

  always_comb begin
    st_nxt     = st;
    res        = '0;
    reject     = 1'b0;
    end_req    = 1'b0;
    end_status = i2cms_pkg::ST_OK;

    unique case (item.action)
      i2cms_pkg::ACT_WRITE, i2cms_pkg::ACT_READ: begin
        if (!busy) begin
          if (item.byte_count == 8'd0) begin
            reject = 1'b1;
          end else begin
            st_nxt.is_read       = (item.action == i2cms_pkg::ACT_READ);
            st_nxt.device        = item.slave_address;
            st_nxt.address       = item.mem_address;
            st_nxt.wide          = item.wide_address;
            st_nxt.remaining     = cnt;
            st_nxt.index         = '0;
            st_nxt.timeout_count = '0;
            st_nxt.retry_count   = '0;
            st_nxt.retry_running = 1'b0;
            st_nxt.phase         = i2cms_pkg::PH_ADDR;
            st_nxt.status        = i2cms_pkg::ST_BUSY;
            res.send_start       = 1'b1;
            res.ack_control      = i2cms_pkg::ACK_CLEAR;
            res.clear_interrupt  = 1'b1;
          end
        end
      end
      i2cms_pkg::ACT_STATUS: begin
        if (busy) begin
          priority case (item.status_code)
            i2cms_pkg::SC_START, i2cms_pkg::SC_RSTART: begin
              if (st.is_read && st.phase != i2cms_pkg::PH_ADDR) begin
                res.tx_byte = st.device | 8'h01;
              end else begin
                res.tx_byte = st.device & i2cms_pkg::DEV_WRITE_MASK;
                if (item.status_code == i2cms_pkg::SC_START) begin
                  st_nxt.retry_running = 1'b1;
                  st_nxt.retry_count   = '0;
                end
              end
              res.tx_valid        = 1'b1;
              res.ack_control     = i2cms_pkg::ACK_SET;
              res.clear_interrupt = 1'b1;
            end
            i2cms_pkg::SC_SLAW_ACK: begin
              st_nxt.retry_running = 1'b0;
              if (st.wide) begin
                res.tx_byte  = st.address[15:8];
                st_nxt.phase = i2cms_pkg::PH_LOWER;
              end else begin
                res.tx_byte  = st.address[7:0];
                st_nxt.phase = i2cms_pkg::PH_DATA;
              end
              res.tx_valid        = 1'b1;
              res.ack_control     = i2cms_pkg::ACK_SET;
              res.clear_interrupt = 1'b1;
            end
            i2cms_pkg::SC_SLAW_NACK: begin
              if (!st.retry_running || st.retry_count >= cfg.retry_ticks) begin
                end_req    = 1'b1;
                end_status = i2cms_pkg::ST_ERR;
              end else begin
                res.send_start      = 1'b1;
                res.ack_control     = i2cms_pkg::ACK_SET;
                res.clear_interrupt = 1'b1;
              end
            end
            i2cms_pkg::SC_TXDATA_ACK: begin
              if (st.phase == i2cms_pkg::PH_LOWER) begin
                res.tx_byte         = st.address[7:0];
                res.tx_valid        = 1'b1;
                st_nxt.phase        = i2cms_pkg::PH_DATA;
                res.ack_control     = i2cms_pkg::ACK_SET;
                res.clear_interrupt = 1'b1;
              end else if (st.phase == i2cms_pkg::PH_DATA) begin
                if (st.is_read) begin
                  // dummy write done: repeated start for the read address
                  res.send_start      = 1'b1;
                  res.clear_interrupt = 1'b1;
                  st_nxt.phase        = i2cms_pkg::PH_RDADDR;
                end else if (st.remaining != 8'd0) begin
                  res.tx_valid        = 1'b1;
                  res.tx_byte         = item.tx_data;
                  res.byte_index      = st.index;
                  st_nxt.remaining    = rem_dec;
                  st_nxt.index        = idx_inc;
                  res.ack_control     = i2cms_pkg::ACK_SET;
                  res.clear_interrupt = 1'b1;
                end else begin
                  end_req = 1'b1;
                end
              end
            end
            i2cms_pkg::SC_ARB_LOST: begin
              res.send_start      = 1'b1;
              res.ack_control     = i2cms_pkg::ACK_SET;
              res.clear_interrupt = 1'b1;
            end
            i2cms_pkg::SC_SLAR_ACK: begin
              // a single byte read is NACKed straight away
              res.ack_control     = (st.remaining <= 8'd1) ? i2cms_pkg::ACK_CLEAR
                                                           : i2cms_pkg::ACK_SET;
              res.clear_interrupt = 1'b1;
            end
            i2cms_pkg::SC_RXDATA_ACK: begin
              if (st.remaining == 8'd0) begin
                end_req = 1'b1;
              end else begin
                res.rx_valid     = 1'b1;
                res.rx_byte      = item.rx_data;
                res.byte_index   = st.index;
                st_nxt.remaining = rem_dec;
                st_nxt.index     = idx_inc;
                if (rem_dec == 8'd1) begin
                  res.ack_control     = i2cms_pkg::ACK_CLEAR;
                  res.clear_interrupt = 1'b1;
                end else if (rem_dec == 8'd0) begin
                  end_req = 1'b1;
                end else begin
                  res.ack_control     = i2cms_pkg::ACK_SET;
                  res.clear_interrupt = 1'b1;
                end
              end
            end
            i2cms_pkg::SC_RXDATA_NACK: begin
              if (st.remaining != 8'd0) begin
                res.rx_valid     = 1'b1;
                res.rx_byte      = item.rx_data;
                res.byte_index   = st.index;
                st_nxt.remaining = rem_dec;
                st_nxt.index     = idx_inc;
              end
              end_req = 1'b1;
            end
            default: begin
              end_req    = 1'b1;
              end_status = i2cms_pkg::ST_ERR;
            end
          endcase
        end
      end
      i2cms_pkg::ACT_TICK: begin
        if (busy) begin
          st_nxt.timeout_count = tmo_inc;
          if (st.retry_running && st.retry_count != 10'h3FF) begin
            st_nxt.retry_count = st.retry_count + 10'd1;
          end
          if (tmo_inc >= cfg.timeout_ticks) begin
            end_req    = 1'b1;
            end_status = i2cms_pkg::ST_ERR;
          end
        end
      end
      default: begin
      end
    endcase

    if (end_req) begin
      res.send_stop        = 1'b1;
      res.clear_interrupt  = 1'b1;
      res.done_res         = 1'b1;
      st_nxt.status        = end_status;
      st_nxt.phase         = i2cms_pkg::PH_IDLE;
      st_nxt.retry_running = 1'b0;
    end

    if (reject) begin
      res.done_res  = 1'b1;
      res.op_status = i2cms_pkg::ST_ERR;
    end else begin
      res.op_status = st_nxt.status;
    end
  end

endmodule
`default_nettype wire

// File: sv/i2c_master_memory_transfer_sequencer.sv
// I2C master memory transfer sequencer. Drives a byte-level I2C controller
// through a memory write or a random read (dummy write of the memory address,
// repeated START, then reads with the last byte NACKed). Each item on in_ch is
// a start request, a controller status event or a time tick, and produces
// exactly one result on out_ch carrying the control actions for the controller.
// Throughput is one item per clock unless out_ch stalls; the sequencer state
// is updated as an item moves from the input register to the result register.
// in_ch.ready only drops while a result waits on a stalled out_ch with a
// further item already held. Configuration (timeout, retry window) is written
// through cfg_we / cfg_index / cfg_wdata by the user only while the block is
// idle; the block does not enforce this. There is no clearing pass after reset.
`default_nettype none
module i2c_master_memory_transfer_sequencer #(
  parameter logic [7:0] MAX_TRANSFER = i2cms_pkg::MAX_TRANSFER
) (
  input  wire                 clk,
  input  wire                 rst_n,
  i2cms_in_if.sink            in_ch,
  i2cms_out_if.source         out_ch,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire  [15:0]         cfg_wdata
);

  // input register
  i2cms_pkg::item_t   in_r;
  logic               in_valid_r;

  // result register
  i2cms_pkg::result_t out_r;
  logic               out_valid_r;

  // sequencer state and configuration
  i2cms_pkg::state_t  state_r;
  i2cms_pkg::state_t  state_nxt;
  i2cms_pkg::cfg_t    cfg_r;
  i2cms_pkg::result_t res_nxt;

  i2cms_pkg::item_t   in_item;

  logic advance;

  // an item moves on when the result register is free or being emptied
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  assign in_item.action        = in_ch.action;
  assign in_item.slave_address = in_ch.slave_address;
  assign in_item.mem_address   = in_ch.mem_address;
  assign in_item.wide_address  = in_ch.wide_address;
  assign in_item.byte_count    = in_ch.byte_count;
  assign in_item.status_code   = in_ch.status_code;
  assign in_item.rx_data       = in_ch.rx_data;
  assign in_item.tx_data       = in_ch.tx_data;

  i2cms_step #(
    .MAX_TRANSFER (MAX_TRANSFER)
  ) u_step (
    .st     (state_r),
    .item   (in_r),
    .cfg    (cfg_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // input side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_item;
    end
  end

  // state update happens exactly once per item, as it moves to the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= i2cms_pkg::PH_IDLE;
      state_r.is_read       <= 1'b0;
      state_r.status        <= i2cms_pkg::ST_OK;
      state_r.remaining     <= '0;
      state_r.index         <= '0;
      state_r.device        <= '0;
      state_r.address       <= '0;
      state_r.wide          <= 1'b0;
      state_r.timeout_count <= '0;
      state_r.retry_count   <= '0;
      state_r.retry_running <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= i2cms_pkg::TIMEOUT_RESET;
      cfg_r.retry_ticks   <= i2cms_pkg::RETRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cms_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        i2cms_pkg::CFG_RETRY:   cfg_r.retry_ticks   <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.send_start      = out_r.send_start;
  assign out_ch.send_stop       = out_r.send_stop;
  assign out_ch.ack_control     = out_r.ack_control;
  assign out_ch.clear_interrupt = out_r.clear_interrupt;
  assign out_ch.tx_valid        = out_r.tx_valid;
  assign out_ch.tx_byte         = out_r.tx_byte;
  assign out_ch.rx_valid        = out_r.rx_valid;
  assign out_ch.rx_byte         = out_r.rx_byte;
  assign out_ch.byte_index      = out_r.byte_index;
  assign out_ch.op_status       = out_r.op_status;
  assign out_ch.done_res        = out_r.done_res;

  // a transfer is busy exactly while the sequencer is out of idle
  a_busy_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.status == i2cms_pkg::ST_BUSY) == (state_r.phase != i2cms_pkg::PH_IDLE))
    else $error("busy status and phase disagree");

  // a finished transfer never reports busy
  a_done_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> (out_r.op_status != i2cms_pkg::ST_BUSY))
    else $error("done result reports busy");

  // every item that leaves the input register lands in the result register
  a_advance_lands : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("item lost between input and result register");

endmodule
`default_nettype wire
